// ----- hdl/evg_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register codes and inter-module types for the voice activity gate.
package evg_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int THR_W      = 46;
   localparam int WIN_W      = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int PREROLL_DEPTH_DEF = 1024;
   localparam int FRAME_LEN_DEF     = 256;
   localparam int SAMPLE_BITS_DEF   = 24;

   localparam int QUEUE_DEPTH = 8;

   localparam int X2_W       = 47;
   localparam int FRAME_W    = 11;
   localparam int FX2_W      = 57;
   localparam int SUM_W      = 34;
   localparam int MAG_W      = 34;
   localparam int HALF_W     = 17;
   localparam int THR_HALF_W = 23;
   localparam int F2_W       = 21;
   localparam int ACC_W      = 68;
   localparam int MUL_A_W    = THR_HALF_W;
   localparam int MUL_B_W    = F2_W;

   localparam logic [THR_W-1:0] THR_RESET  = THR_W'(1048576);
   localparam logic [WIN_W-1:0] WIN_RESET  = WIN_W'(16000);
   localparam logic             GATE_RESET = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WINDOW    = 2'd1,
      CSR_GATE      = 2'd2
   } evg_csr_type;

   typedef struct packed {
      logic [THR_W-1:0] vad_threshold;
      logic [WIN_W-1:0] window_length;
      logic             gate_enable;
   } evg_cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x;
      logic [FX2_W-1:0]           fx2;
   } evg_item_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum;
      logic [ACC_W-1:0]        psq;
   } evg_test_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } evg_test_rsp_type;

endpackage

// ----- hdl/evg_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module evg_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/evg_queue.sv -----
`timescale 1ns / 1ps
// Short register queue that decouples the front pipeline from the back end.
module evg_queue #(
   parameter int DEPTH = evg_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  evg_pkg::evg_item_type item_in,
   input  logic                  pop,
   output logic                  head_valid,
   output evg_pkg::evg_item_type head_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   evg_pkg::evg_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

endmodule

// ----- hdl/evg_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts samples, sign-extends them and forms the scaled square for the frame sums.
module evg_front #(
   parameter int SAMPLE_BITS = evg_pkg::SAMPLE_BITS_DEF,
   parameter int FRAME_LEN   = evg_pkg::FRAME_LEN_DEF,
   parameter int QUEUE_DEPTH = evg_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [evg_pkg::SAMPLE_W-1:0] req_in_sample,
   input  logic                                pop,
   output logic                                push,
   output evg_pkg::evg_item_type               item
);

   localparam int SHIFT = evg_pkg::SAMPLE_W - SAMPLE_BITS;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [evg_pkg::FRAME_W-1:0] FRAME_K = evg_pkg::FRAME_W'(FRAME_LEN);

   logic                                accept;
   logic signed [evg_pkg::SAMPLE_W-1:0] shifted;
   logic signed [evg_pkg::SAMPLE_W-1:0] x_ext;
   logic signed [2*evg_pkg::SAMPLE_W-1:0] sq_full;
   logic [evg_pkg::X2_W+evg_pkg::FRAME_W-1:0] fx2_full;

   logic [OCC_W-1:0] occ_ff, occ_in;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic signed [evg_pkg::SAMPLE_W-1:0] s1_x_ff, s2_x_ff, s3_x_ff;
   logic [evg_pkg::X2_W-1:0]            s2_sq_ff;
   logic [evg_pkg::FX2_W-1:0]           s3_fx2_ff;

   assign req_ready = (occ_ff < OCC_W'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   assign shifted   = req_in_sample <<< SHIFT;
   assign x_ext     = shifted >>> SHIFT;
   assign sq_full   = s1_x_ff * s1_x_ff;
   assign fx2_full  = s2_sq_ff * FRAME_K;
   assign occ_in    = occ_ff + OCC_W'(accept) - OCC_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff   <= x_ext;
      s2_x_ff   <= s1_x_ff;
      s2_sq_ff  <= sq_full[evg_pkg::X2_W-1:0];
      s3_x_ff   <= s2_x_ff;
      s3_fx2_ff <= fx2_full[evg_pkg::FX2_W-1:0];
   end

   assign push     = s3_valid_ff;
   assign item.x   = s3_x_ff;
   assign item.fx2 = s3_fx2_ff;

endmodule

// ----- hdl/evg_onset.sv -----
`timescale 1ns / 1ps
// Frame onset test: sequences the variance comparison through one shared multiplier.
module evg_onset #(
   parameter int FRAME_LEN = evg_pkg::FRAME_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [evg_pkg::THR_W-1:0]       threshold,
   input  evg_pkg::evg_test_req_type       test_req,
   output evg_pkg::evg_test_rsp_type       test_rsp
);

   localparam logic [evg_pkg::F2_W-1:0] F2 = evg_pkg::F2_W'(FRAME_LEN * FRAME_LEN);
   localparam int HW = evg_pkg::HALF_W;
   localparam int TH = evg_pkg::THR_HALF_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LL,
      ST_HL,
      ST_HH,
      ST_TL,
      ST_TH,
      ST_CMP
   } state_type;

   state_type                      state_ff, state_in;
   logic [evg_pkg::MAG_W-1:0]      mag_ff, mag_in;
   logic [evg_pkg::ACC_W-1:0]      psq_ff, psq_in;
   logic [evg_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic [evg_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic [evg_pkg::MUL_A_W-1:0]    mul_a;
   logic [evg_pkg::MUL_B_W-1:0]    mul_b;
   logic [evg_pkg::MUL_A_W+evg_pkg::MUL_B_W-1:0] prod;

   assign prod = mul_a * mul_b;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      psq_in   = psq_ff;
      thr_in   = thr_ff;
      acc_in   = acc_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (test_req.start) begin
               mag_in   = test_req.sum[evg_pkg::SUM_W-1]
                        ? (evg_pkg::MAG_W'(0) - evg_pkg::MAG_W'(test_req.sum))
                        : evg_pkg::MAG_W'(test_req.sum);
               psq_in   = test_req.psq;
               thr_in   = threshold;
               acc_in   = '0;
               state_in = ST_LL;
            end
         end
         ST_LL: begin
            mul_a    = evg_pkg::MUL_A_W'(mag_ff[HW-1:0]);
            mul_b    = evg_pkg::MUL_B_W'(mag_ff[HW-1:0]);
            acc_in   = acc_ff + evg_pkg::ACC_W'(prod);
            state_in = ST_HL;
         end
         ST_HL: begin
            mul_a    = evg_pkg::MUL_A_W'(mag_ff[evg_pkg::MAG_W-1:HW]);
            mul_b    = evg_pkg::MUL_B_W'(mag_ff[HW-1:0]);
            acc_in   = acc_ff + (evg_pkg::ACC_W'(prod) << (HW + 1));
            state_in = ST_HH;
         end
         ST_HH: begin
            mul_a    = evg_pkg::MUL_A_W'(mag_ff[evg_pkg::MAG_W-1:HW]);
            mul_b    = evg_pkg::MUL_B_W'(mag_ff[evg_pkg::MAG_W-1:HW]);
            acc_in   = acc_ff + (evg_pkg::ACC_W'(prod) << (2 * HW));
            state_in = ST_TL;
         end
         ST_TL: begin
            mul_a    = thr_ff[TH-1:0];
            mul_b    = F2;
            acc_in   = acc_ff + evg_pkg::ACC_W'(prod);
            state_in = ST_TH;
         end
         ST_TH: begin
            mul_a    = thr_ff[evg_pkg::THR_W-1:TH];
            mul_b    = F2;
            acc_in   = acc_ff + (evg_pkg::ACC_W'(prod) << TH);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      psq_ff <= psq_in;
      thr_ff <= thr_in;
      acc_ff <= acc_in;
   end

   // A negative variance is clamped to zero, so a zero threshold always fires.
   assign test_rsp.busy = (state_ff != ST_IDLE);
   assign test_rsp.done = (state_ff == ST_CMP);
   assign test_rsp.hit  = (psq_ff >= acc_ff) || (thr_ff == '0);

endmodule

// ----- hdl/evg_back.sv -----
`timescale 1ns / 1ps
// Back end: frame accumulation, pre-roll ring control, window counting and the output register.
module evg_back #(
   parameter int PREROLL_DEPTH = evg_pkg::PREROLL_DEPTH_DEF,
   parameter int FRAME_LEN     = evg_pkg::FRAME_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  evg_pkg::evg_cfg_type                cfg,
   input  logic                                head_valid,
   input  evg_pkg::evg_item_type               head_item,
   output logic                                head_pop,
   output evg_pkg::evg_test_req_type           test_req,
   input  evg_pkg::evg_test_rsp_type           test_rsp,
   output logic                                ram_wr_en,
   output logic [$clog2(PREROLL_DEPTH)-1:0]    ram_wr_addr,
   output logic [evg_pkg::SAMPLE_W-1:0]        ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(PREROLL_DEPTH)-1:0]    ram_rd_addr,
   input  logic [evg_pkg::SAMPLE_W-1:0]        ram_rd_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [evg_pkg::SAMPLE_W-1:0] rsp_out_sample,
   output logic                                rsp_window_end
);

   localparam int PTR_W  = $clog2(PREROLL_DEPTH);
   localparam int FILL_W = $clog2(PREROLL_DEPTH + 1);
   localparam int POS_W  = $clog2(FRAME_LEN);

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic signed [evg_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [evg_pkg::ACC_W-1:0]        psq_ff, psq_in;
   logic                             capt_ff, capt_in;
   logic [evg_pkg::WIN_W-1:0]        count_ff, count_in;

   logic                             b_valid_ff, b_valid_in;
   logic                             b_ram_ff, b_ram_in;
   logic signed [evg_pkg::SAMPLE_W-1:0] b_x_ff, b_x_in;
   logic                             b_end_ff, b_end_in;

   logic                             slot_free;
   logic                             listen;
   logic                             take;
   logic                             frame_last;
   logic                             ring_used;
   logic signed [evg_pkg::SUM_W-1:0] sum_next;
   logic [evg_pkg::ACC_W-1:0]        psq_next;
   logic [evg_pkg::WIN_W-1:0]        count_next;
   logic                             win_end;
   logic [FILL_W-1:0]                wp_ext;
   logic [FILL_W-1:0]                start_sel;
   logic [PTR_W-1:0]                 onset_rp;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(PREROLL_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign slot_free  = !b_valid_ff || rsp_ready;
   assign listen     = !capt_ff && cfg.gate_enable;
   assign take       = head_valid && !test_rsp.busy && (listen || slot_free);
   assign head_pop   = take;
   assign frame_last = (pos_ff == POS_W'(FRAME_LEN - 1));
   assign ring_used  = capt_ff && (fill_ff != '0);
   assign sum_next   = sum_ff + evg_pkg::SUM_W'(head_item.x);
   assign psq_next   = psq_ff + evg_pkg::ACC_W'(head_item.fx2);
   assign count_next = (capt_ff ? count_ff : '0) + 1'b1;
   assign win_end    = (count_next == cfg.window_length);

   // The oldest held sample sits fill entries behind the write pointer.
   assign wp_ext    = FILL_W'(wp_ff);
   assign start_sel = (wp_ext >= fill_ff) ? (wp_ext - fill_ff)
                                          : (wp_ext + FILL_W'(PREROLL_DEPTH) - fill_ff);
   assign onset_rp  = start_sel[PTR_W-1:0];

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      psq_in      = psq_ff;
      capt_in     = capt_ff;
      count_in    = count_ff;
      b_valid_in  = b_valid_ff && !rsp_ready;
      b_ram_in    = b_ram_ff;
      b_x_in      = b_x_ff;
      b_end_in    = b_end_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wp_ff;
      ram_wr_data = head_item.x;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rp_ff;
      test_req.start = 1'b0;
      test_req.sum   = sum_next;
      test_req.psq   = psq_next;

      if (test_rsp.done && test_rsp.hit) begin
         capt_in  = 1'b1;
         count_in = '0;
         rp_in    = onset_rp;
      end

      if (take) begin
         if (listen) begin
            ram_wr_en = 1'b1;
            wp_in     = ptr_inc(wp_ff);
            if (fill_ff != FILL_W'(PREROLL_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            if (frame_last) begin
               test_req.start = 1'b1;
               pos_in = '0;
               sum_in = '0;
               psq_in = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
               sum_in = sum_next;
               psq_in = psq_next;
            end
         end else begin
            pos_in     = '0;
            sum_in     = '0;
            psq_in     = '0;
            b_valid_in = 1'b1;
            b_x_in     = head_item.x;
            b_end_in   = win_end;
            if (ring_used) begin
               ram_rd_en = 1'b1;
               ram_wr_en = 1'b1;
               wp_in     = ptr_inc(wp_ff);
               rp_in     = ptr_inc(rp_ff);
               b_ram_in  = 1'b1;
            end else begin
               wp_in    = '0;
               rp_in    = '0;
               fill_in  = '0;
               b_ram_in = 1'b0;
            end
            if (win_end) begin
               capt_in  = 1'b0;
               count_in = '0;
               wp_in    = '0;
               rp_in    = '0;
               fill_in  = '0;
            end else begin
               capt_in  = 1'b1;
               count_in = count_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         fill_ff    <= '0;
         pos_ff     <= '0;
         sum_ff     <= '0;
         psq_ff     <= '0;
         capt_ff    <= 1'b0;
         count_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         fill_ff    <= fill_in;
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         psq_ff     <= psq_in;
         capt_ff    <= capt_in;
         count_ff   <= count_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ram_ff <= b_ram_in;
      b_x_ff   <= b_x_in;
      b_end_ff <= b_end_in;
   end

   assign rsp_valid      = b_valid_ff;
   assign rsp_out_sample = b_ram_ff ? $signed(ram_rd_data) : b_x_ff;
   assign rsp_window_end = b_end_ff;

endmodule

// ----- hdl/energy_vad_gate_with_preroll_unit.sv -----
`timescale 1ns / 1ps
// Top level of the energy-gated audio window capture with pre-roll.
//
// Samples enter through a three-stage front pipeline (sign extension, squaring, frame scaling)
// into an eight-entry queue, and the back end takes one sample per cycle from it while no onset
// test runs and no stalled result blocks it; a new transaction is accepted every cycle while
// the queue has room, and a result waiting on rsp_ready does not block the input until the queue
// fills. Each FRAME_LEN-th sample while listening starts the onset test, which runs through one
// shared multiplier and holds the back end until it is done; capture runs at one sample per
// cycle while rsp_ready allows. The pre-roll ring is a single-port-write, registered-read RAM
// used as a delay line, and the ring has no clearing pass after reset.
module energy_vad_gate_with_preroll_unit #(
   parameter int PREROLL_DEPTH = evg_pkg::PREROLL_DEPTH_DEF,
   parameter int FRAME_LEN     = evg_pkg::FRAME_LEN_DEF,
   parameter int SAMPLE_BITS   = evg_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [evg_pkg::SAMPLE_W-1:0]  req_in_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [evg_pkg::SAMPLE_W-1:0]  rsp_out_sample,
   output logic                                 rsp_window_end,
   input  logic                                 csr_we,
   input  logic [evg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [evg_pkg::THR_W-1:0]            csr_wdata
);

   localparam int PTR_W = $clog2(PREROLL_DEPTH);

   evg_pkg::evg_cfg_type      cfg_ff, cfg_in;
   logic                      push;
   evg_pkg::evg_item_type     push_item;
   logic                      head_valid;
   evg_pkg::evg_item_type     head_item;
   logic                      head_pop;
   evg_pkg::evg_test_req_type test_req;
   evg_pkg::evg_test_rsp_type test_rsp;
   logic                      ram_wr_en;
   logic [PTR_W-1:0]          ram_wr_addr;
   logic [evg_pkg::SAMPLE_W-1:0] ram_wr_data;
   logic                      ram_rd_en;
   logic [PTR_W-1:0]          ram_rd_addr;
   logic [evg_pkg::SAMPLE_W-1:0] ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            evg_pkg::CSR_THRESHOLD: cfg_in.vad_threshold = csr_wdata;
            evg_pkg::CSR_WINDOW:    cfg_in.window_length = csr_wdata[evg_pkg::WIN_W-1:0];
            evg_pkg::CSR_GATE:      cfg_in.gate_enable   = csr_wdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vad_threshold <= evg_pkg::THR_RESET;
         cfg_ff.window_length <= evg_pkg::WIN_RESET;
         cfg_ff.gate_enable   <= evg_pkg::GATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evg_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAME_LEN   (FRAME_LEN),
      .QUEUE_DEPTH (evg_pkg::QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_sample (req_in_sample),
      .pop           (head_pop),
      .push          (push),
      .item          (push_item)
   );

   evg_queue #(
      .DEPTH (evg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .item_in    (push_item),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   evg_onset #(
      .FRAME_LEN (FRAME_LEN)
   ) u_onset (
      .clock     (clock),
      .reset     (reset),
      .threshold (cfg_ff.vad_threshold),
      .test_req  (test_req),
      .test_rsp  (test_rsp)
   );

   evg_ram #(
      .WIDTH (evg_pkg::SAMPLE_W),
      .DEPTH (PREROLL_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   evg_back #(
      .PREROLL_DEPTH (PREROLL_DEPTH),
      .FRAME_LEN     (FRAME_LEN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop),
      .test_req       (test_req),
      .test_rsp       (test_rsp),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .rsp_window_end (rsp_window_end)
   );

endmodule

// ----- verif/evg_capture_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts every window sample of the voice activity gate and compares it.
module evg_capture_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [evg_pkg::SAMPLE_W-1:0] req_in_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [evg_pkg::SAMPLE_W-1:0] rsp_out_sample,
   input  logic                                rsp_window_end,
   input  logic                                csr_we,
   input  logic [evg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [evg_pkg::THR_W-1:0]           csr_wdata,
   output int                                  samples_due,
   output logic                                window_open,
   output int                                  mismatches
);

   localparam int RING_DEPTH = evg_pkg::PREROLL_DEPTH_DEF;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int FRAME_LEN  = evg_pkg::FRAME_LEN_DEF;

   typedef struct {
      logic signed [evg_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } window_sample_type;

   window_sample_type                   window_samples_due[$];
   logic signed [evg_pkg::SAMPLE_W-1:0] preroll[RING_DEPTH];
   logic [RING_AW-1:0]                  wr_ptr;
   logic [RING_AW-1:0]                  rd_ptr;
   int unsigned                         held;
   int unsigned                         frame_pos;
   longint                              frame_sum;
   logic [63:0]                         frame_sumsq;
   logic                                capturing;
   logic [evg_pkg::WIN_W-1:0]           emitted;
   evg_pkg::evg_cfg_type                cfg;

   // Integer form of the variance test; a negative variance counts as zero.
   function automatic logic onset(input longint sum, input logic [63:0] sumsq,
                                  input logic [evg_pkg::THR_W-1:0] thr);
      logic [127:0] scaled;
      logic [127:0] sq;
      logic [127:0] excess;
      logic [127:0] bar;
      logic [63:0]  mag;
      mag    = (sum < 0) ? 64'(-sum) : 64'(sum);
      scaled = 128'(sumsq) * 128'(FRAME_LEN);
      sq     = 128'(mag) * 128'(mag);
      excess = (scaled >= sq) ? scaled - sq : '0;
      bar    = 128'(thr) * 128'(FRAME_LEN * FRAME_LEN);
      return excess >= bar;
   endfunction

   task automatic clear_frame();
      frame_pos   = 0;
      frame_sum   = 0;
      frame_sumsq = '0;
   endtask

   task automatic empty_ring();
      wr_ptr = '0;
      rd_ptr = '0;
      held   = 0;
   endtask

   task automatic gate_sample(input logic signed [evg_pkg::SAMPLE_W-1:0] x);
      window_sample_type due;
      logic              hit;
      if (!capturing && !cfg.gate_enable) begin
         empty_ring();
         clear_frame();
         capturing = 1'b1;
         emitted   = '0;
      end
      if (!capturing) begin
         preroll[wr_ptr] = x;
         wr_ptr++;
         if (held < RING_DEPTH) begin
            held++;
         end
         frame_sum   += x;
         frame_sumsq += 64'(longint'(x) * longint'(x));
         frame_pos++;
         if (frame_pos >= FRAME_LEN) begin
            hit = onset(frame_sum, frame_sumsq, cfg.vad_threshold);
            clear_frame();
            if (hit) begin
               capturing = 1'b1;
               emitted   = '0;
               rd_ptr    = wr_ptr - RING_AW'(held);
            end
         end
      end else begin
         if (held == 0) begin
            due.sample = x;
         end else begin
            due.sample      = preroll[rd_ptr];
            preroll[wr_ptr] = x;
            wr_ptr++;
            rd_ptr++;
         end
         emitted++;
         due.last = (emitted == cfg.window_length);
         window_samples_due.push_back(due);
         if (due.last) begin
            capturing = 1'b0;
            emitted   = '0;
            empty_ring();
            clear_frame();
         end
      end
   endtask

   // The result transaction is checked before the input one, so that a result can
   // never be matched against a sample accepted at the same edge.
   always @(posedge clock) begin
      window_sample_type due;
      if (reset) begin
         window_samples_due.delete();
         empty_ring();
         clear_frame();
         capturing  = 1'b0;
         emitted    = '0;
         cfg        = '{vad_threshold: evg_pkg::THR_RESET,
                        window_length: evg_pkg::WIN_RESET,
                        gate_enable: evg_pkg::GATE_RESET};
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (window_samples_due.size() == 0) begin
               $display("%0t: unexpected window sample %0d, window_end %0b", $time,
                        rsp_out_sample, rsp_window_end);
               mismatches++;
            end else begin
               due = window_samples_due.pop_front();
               if (rsp_out_sample !== due.sample) begin
                  $display("%0t: out_sample expected %0d, actual %0d", $time,
                           due.sample, rsp_out_sample);
                  mismatches++;
               end
               if (rsp_window_end !== due.last) begin
                  $display("%0t: window_end expected %0b, actual %0b", $time,
                           due.last, rsp_window_end);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            gate_sample(req_in_sample);
         end
         if (csr_we) begin
            case (csr_index)
               evg_pkg::CSR_THRESHOLD: cfg.vad_threshold = csr_wdata;
               evg_pkg::CSR_WINDOW:    cfg.window_length = csr_wdata[evg_pkg::WIN_W-1:0];
               evg_pkg::CSR_GATE:      cfg.gate_enable   = csr_wdata[0];
               default: ;
            endcase
         end
      end
      samples_due = window_samples_due.size();
      window_open = capturing;
   end

endmodule

// ----- verif/tb_energy_vad_gate_with_preroll_unit.sv -----
`timescale 1ns / 1ps
// Testbench top for the voice activity gate: stimulus, register writes and the verdict.
module tb_energy_vad_gate_with_preroll_unit;

   localparam int SAMPLE_W  = evg_pkg::SAMPLE_W;
   localparam int THR_W     = evg_pkg::THR_W;
   localparam int WIN_W     = evg_pkg::WIN_W;
   localparam int CSR_IDX_W = evg_pkg::CSR_IDX_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int FRAME        = evg_pkg::FRAME_LEN_DEF;
   localparam int ITEM_GOAL    = 1900;
   localparam int DRAIN_CYCLES = 48;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_in_sample;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_out_sample;
   logic                       rsp_window_end;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [THR_W-1:0]           csr_wdata;

   int   samples_due;
   int   mismatches;
   logic window_open;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   items_sent     = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   energy_vad_gate_with_preroll_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .rsp_window_end (rsp_window_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   evg_capture_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_sample  (req_in_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_sample (rsp_out_sample),
      .rsp_window_end (rsp_window_end),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .samples_due    (samples_due),
      .window_open    (window_open),
      .mismatches     (mismatches)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic signed [SAMPLE_W-1:0] noise(input int unsigned amp_bits);
      int span;
      if (amp_bits >= SAMPLE_W - 1) begin
         return SAMPLE_W'($urandom);
      end
      span = 1 << amp_bits;
      return SAMPLE_W'(int'($urandom_range(2 * span - 1, 0)) - span);
   endfunction

   // Valid is left high after a transaction so that back-to-back samples need no gap.
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_in_sample <= s;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Samples that produce no result may still be inside the block when the last
   // expected result has arrived, hence the extra cycles.
   task automatic settle();
      req_valid <= 1'b0;
      while (samples_due != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_episode(input int e);
      int               kind;
      int unsigned      amp;
      int               quiet_frames;
      int               n;
      logic             gate;
      logic [THR_W-1:0] thr;
      logic [WIN_W-1:0] wl;
      settle();
      case (e % 4)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
         default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      kind         = (e < 3) ? e : $urandom_range(9);
      gate         = 1'b1;
      thr          = evg_pkg::THR_RESET;
      quiet_frames = 0;
      amp          = $urandom_range(23, 8);
      wl           = ($urandom_range(3) == 0) ? WIN_W'($urandom_range(400, 200))
                                              : WIN_W'($urandom_range(64, 1));
      case (kind)
         0: begin
            quiet_frames = 4;
            amp          = 23;
            wl           = WIN_W'($urandom_range(40, 1));
         end
         1: begin
            thr = '0;
            amp = 3;
         end
         2: thr = '1;
         3, 4, 5: begin
            gate = 1'b0;
            wl   = WIN_W'($urandom_range(24, 1));
         end
         default: thr = THR_W'(1) << $urandom_range(44, 12);
      endcase
      write_reg(evg_pkg::CSR_GATE, THR_W'(gate));
      write_reg(evg_pkg::CSR_THRESHOLD, thr);
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(wl));
      if (kind == 2) begin
         // Full-scale alternation is the largest variance a frame can have.
         for (int i = 0; i < 2 * FRAME; i++) begin
            push_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN);
         end
      end else if (!gate) begin
         n = int'(wl) * int'($urandom_range(4, 1));
         for (int i = 0; i < n; i++) begin
            push_sample(noise($urandom_range(23, 0)));
         end
      end else begin
         for (int i = 0; i < quiet_frames * FRAME; i++) begin
            push_sample(noise(9));
         end
         for (int i = 0; i < 2 * FRAME && !window_open; i++) begin
            push_sample(noise(amp));
         end
      end
      while (window_open) begin
         push_sample(noise($urandom_range(23, 0)));
      end
   endtask

   initial begin
      int e;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_sample = '0;
      csr_we        = 1'b0;
      csr_index     = evg_pkg::CSR_THRESHOLD;
      csr_wdata     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_reg(evg_pkg::CSR_GATE, '0);
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(4));
      push_sample(SAMPLE_MAX);
      push_sample(SAMPLE_MIN);
      push_sample('0);
      push_sample(-24'sd1);
      push_sample(24'sd1);
      push_sample(24'sh555555);
      push_sample(24'shAAAAAA);
      push_sample(24'sh7FFFFE);
      settle();
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(1));
      push_sample(SAMPLE_MIN);
      push_sample(SAMPLE_MAX);
      settle();
      // A long window shortened part-way through, with the gate switched on meanwhile.
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(16'hFFFF));
      push_sample(24'sh123456);
      push_sample(-24'sd77);
      push_sample(24'sh400000);
      settle();
      write_reg(evg_pkg::CSR_GATE, THR_W'(1));
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(5));
      write_reg(CSR_SPARE, '1);
      push_sample(24'sh0F0F0F);
      push_sample(-24'sd4096);
      push_sample(24'sh3FFFFF);
      settle();
      write_reg(evg_pkg::CSR_GATE, '0);
      write_reg(evg_pkg::CSR_WINDOW, '0);
      push_sample(24'sh000100);
      push_sample(-24'sh000100);
      push_sample(24'sh7F0000);
      settle();
      write_reg(evg_pkg::CSR_WINDOW, THR_W'(4));
      push_sample(-24'sh7F0000);

      for (e = 0; items_sent < ITEM_GOAL; e++) begin
         run_episode(e);
      end

      req_valid <= 1'b0;
      while (samples_due != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && samples_due == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
